// ===== sv/ola_pkg.sv =====
package ola_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int CAP_W  = 7;
  localparam int WORD_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    F_INSERT = 3'd0,
    F_APPEND = 3'd1,
    F_READ   = 3'd2,
    F_DELETE = 3'd3,
    F_EDIT   = 3'd4,
    F_CLEAR  = 3'd5
  } ola_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BADIDX   = 2'd1,
    ST_OVERFLOW = 2'd2
  } ola_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_READ
  } ola_state_e;

endpackage

// ===== sv/ordered_array_list.sv =====
// Ordered list of up to 64 signed 32-bit words held in a single-port-write,
// registered-read memory. A command beat is taken when start is high and busy
// is low; exactly one result follows, shown for one cycle with done_o high,
// and the receiver must capture it then because it cannot be held off. Read,
// edit, append, clear and failed commands, and inserts or deletes that move no
// entry, finish in the execute state or in the read or put state after it.
// Insert and delete move the later entries one per cycle through the memory:
// the shift state steps through them, a drain state writes the last one, and
// an insert then writes its new word in the put state. busy is low again in the
// cycle that shows the result, so the next command may start there. The user
// must write the capacity register with cfg_we_i only while no command is in
// flight; the block does not enforce this.
module ordered_array_list (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ola_pkg::FUNC_W-1:0] func_i,
  input  logic [ola_pkg::POS_W-1:0]  position_i,
  input  logic signed [ola_pkg::WORD_W-1:0] word_in_i,
  input  logic                       cfg_we_i,
  input  logic [ola_pkg::CAP_W-1:0]  cfg_wdata_i,
  output logic                       done_o,
  output logic signed [ola_pkg::WORD_W-1:0] read_word_o,
  output logic [ola_pkg::STAT_W-1:0] status_o,
  output logic [ola_pkg::CNT_W-1:0]  occupancy_o,
  output logic                       is_empty_o,
  output logic                       is_full_o
);
  import ola_pkg::*;

  ola_state_e        state_q, state_d;
  ola_func_e         func_q, func_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  rp_q, rp_d;
  logic              mv_q, mv_d;
  logic [IDX_W-1:0]  mv_addr_q, mv_addr_d;
  logic              done_q, done_d;
  logic [WORD_W-1:0] rw_q, rw_d;
  ola_status_e       st_q, st_d;
  logic              full_q, full_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              fin;
  ola_status_e       fin_st;
  logic [WORD_W-1:0] fin_rw;

  logic [CMP_W-1:0]  cnt_x, pos_x, cap_x;
  logic              list_full;
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  last_idx;

  assign cnt_x     = CMP_W'(cnt_q);
  assign pos_x     = CMP_W'(pos_q);
  assign cap_x     = CMP_W'(cap_q);
  assign list_full = (cnt_x >= cap_x) || (cnt_q == CNT_W'(DEPTH));
  assign pos_idx   = IDX_W'(pos_q);
  assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));

  ola_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    pos_d     = pos_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    rp_d      = rp_q;
    mv_d      = 1'b0;
    mv_addr_d = mv_addr_q;
    done_d    = 1'b0;
    rw_d      = rw_q;
    st_d      = st_q;
    full_d    = full_q;
    mem_we    = 1'b0;
    mem_waddr = mv_addr_q;
    mem_wdata = mem_rdata;
    mem_raddr = rp_q;
    fin       = 1'b0;
    fin_st    = ST_DONE;
    fin_rw    = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d  = ola_func_e'(func_i);
          pos_d   = position_i;
          word_d  = word_in_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_q)
          F_INSERT: begin
            if (pos_x > cnt_x) begin
              fin    = 1'b1;
              fin_st = ST_BADIDX;
            end else if (list_full) begin
              fin    = 1'b1;
              fin_st = ST_OVERFLOW;
            end else if (pos_x < cnt_x) begin
              rp_d    = last_idx;
              state_d = S_SHIFT;
            end else begin
              state_d = S_PUT;
            end
          end
          F_APPEND: begin
            if (list_full) begin
              fin    = 1'b1;
              fin_st = ST_OVERFLOW;
            end else begin
              pos_d   = POS_W'(cnt_q);
              state_d = S_PUT;
            end
          end
          F_READ: begin
            mem_raddr = pos_idx;
            if (pos_x >= cnt_x) begin
              fin    = 1'b1;
              fin_st = ST_BADIDX;
              fin_rw = '1;
            end else begin
              state_d = S_READ;
            end
          end
          F_DELETE: begin
            if (pos_x >= cnt_x) begin
              fin    = 1'b1;
              fin_st = ST_BADIDX;
            end else if (pos_x + CMP_W'(1) < cnt_x) begin
              rp_d    = pos_idx + IDX_W'(1);
              state_d = S_SHIFT;
            end else begin
              cnt_d = cnt_q - CNT_W'(1);
              fin   = 1'b1;
            end
          end
          F_EDIT: begin
            if (pos_x >= cnt_x) begin
              fin    = 1'b1;
              fin_st = ST_BADIDX;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pos_idx;
              mem_wdata = word_q;
              fin       = 1'b1;
            end
          end
          F_CLEAR: begin
            cnt_d = '0;
            fin   = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        mem_raddr = rp_q;
        mem_we    = mv_q;
        mv_d      = 1'b1;
        if (func_q == F_INSERT) begin
          mv_addr_d = rp_q + IDX_W'(1);
          if (rp_q == pos_idx) begin
            state_d = S_DRAIN;
          end else begin
            rp_d = rp_q - IDX_W'(1);
          end
        end else begin
          mv_addr_d = rp_q - IDX_W'(1);
          if (rp_q == last_idx) begin
            state_d = S_DRAIN;
          end else begin
            rp_d = rp_q + IDX_W'(1);
          end
        end
      end
      S_DRAIN: begin
        mem_we = mv_q;
        if (func_q == F_INSERT) begin
          state_d = S_PUT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          fin   = 1'b1;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_idx;
        mem_wdata = word_q;
        cnt_d     = cnt_q + CNT_W'(1);
        fin       = 1'b1;
      end
      S_READ: begin
        fin    = 1'b1;
        fin_rw = mem_rdata;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      done_d  = 1'b1;
      st_d    = fin_st;
      rw_d    = fin_rw;
      full_d  = (CMP_W'(cnt_d) >= cap_x) || (cnt_d == CNT_W'(DEPTH));
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cap_q   <= CAP_RESET;
      mv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    pos_q     <= pos_d;
    word_q    <= word_d;
    rp_q      <= rp_d;
    mv_addr_q <= mv_addr_d;
    rw_q      <= rw_d;
    st_q      <= st_d;
    full_q    <= full_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign read_word_o = rw_q;
  assign status_o    = st_q;
  assign occupancy_o = cnt_q;
  assign is_empty_o  = (cnt_q == '0);
  assign is_full_o   = full_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("occupancy beyond list depth");

  a_start_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_EXEC))
    else $error("accepted command did not reach execute");

  a_move_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q |-> $past(state_q == S_SHIFT))
    else $error("pending move without a shift read");

  a_cnt_stable_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q == S_IDLE) && !$past(done_d)) |-> $stable(cnt_q))
    else $error("occupancy changed while idle");

endmodule

// ===== sv/ola_store.sv =====
module ola_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ola_pkg::IDX_W-1:0]  waddr_i,
  input  logic [ola_pkg::WORD_W-1:0] wdata_i,
  input  logic [ola_pkg::IDX_W-1:0]  raddr_i,
  output logic [ola_pkg::WORD_W-1:0] rdata_o
);
  import ola_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_ordered_array_list.sv =====
`timescale 1ns / 100ps

module tb_ordered_array_list;
  import ola_pkg::*;

  localparam logic [FUNC_W-1:0] F_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] F_SPARE7 = 3'd7;
  localparam int RUN_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 148;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  occupancy;
    logic              is_empty;
    logic              is_full;
  } list_result_t;

  class list_scoreboard;
    logic [WORD_W-1:0] words [DEPTH];
    int occ;
    int cap;
    int errors;
    list_result_t pending_results[$];

    function new();
      occ    = 0;
      cap    = int'(CAP_RESET);
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      cap = int'(value);
    endfunction

    function void note_command(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                               logic [WORD_W-1:0] w);
      list_result_t r;
      int eff;
      int pi;
      bit full;
      eff         = (cap > DEPTH) ? DEPTH : cap;
      full        = (occ >= eff);
      pi          = int'(p);
      r.read_word = '0;
      r.status    = ST_DONE;
      case (f)
        F_INSERT: begin
          if (pi > occ) begin
            r.status = ST_BADIDX;
          end else if (full) begin
            r.status = ST_OVERFLOW;
          end else begin
            for (int i = occ; i > pi; i--) words[i] = words[i-1];
            words[pi] = w;
            occ++;
          end
        end
        F_APPEND: begin
          if (full) begin
            r.status = ST_OVERFLOW;
          end else begin
            words[occ] = w;
            occ++;
          end
        end
        F_READ: begin
          if (pi >= occ) begin
            r.status    = ST_BADIDX;
            r.read_word = '1;
          end else begin
            r.read_word = words[pi];
          end
        end
        F_DELETE: begin
          if (pi >= occ) begin
            r.status = ST_BADIDX;
          end else begin
            for (int i = pi; i + 1 < occ; i++) words[i] = words[i+1];
            occ--;
          end
        end
        F_EDIT: begin
          if (pi >= occ) begin
            r.status = ST_BADIDX;
          end else begin
            words[pi] = w;
          end
        end
        F_CLEAR: begin
          occ = 0;
        end
        default: begin
        end
      endcase
      r.occupancy = CNT_W'(occ);
      r.is_empty  = (occ == 0);
      r.is_full   = (occ >= eff);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] exp_v,
                                logic [WORD_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with no command pending, expected none, actual %h",
                 $time, got);
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("read_word", exp_r.read_word, got.read_word);
      compare_field("status", WORD_W'(exp_r.status), WORD_W'(got.status));
      compare_field("occupancy", WORD_W'(exp_r.occupancy), WORD_W'(got.occupancy));
      compare_field("is_empty", WORD_W'(exp_r.is_empty), WORD_W'(got.is_empty));
      compare_field("is_full", WORD_W'(exp_r.is_full), WORD_W'(got.is_full));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   func_i      = '0;
  logic [POS_W-1:0]    position_i  = '0;
  logic signed [WORD_W-1:0] word_in_i = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata_i = '0;
  logic                done_o;
  logic signed [WORD_W-1:0] read_word_o;
  logic [STAT_W-1:0]   status_o;
  logic [CNT_W-1:0]    occupancy_o;
  logic                is_empty_o;
  logic                is_full_o;

  list_scoreboard sb = new();
  int  cycles     = 0;
  bit  idle_on    = 1'b1;
  int  burst_left = 0;

  ordered_array_list i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .position_i  (position_i),
    .word_in_i   (word_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .read_word_o (read_word_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result('{read_word_o, status_o, occupancy_o, is_empty_o, is_full_o});
    end
  end

  task automatic send_command(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                              logic [WORD_W-1:0] w);
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      idle_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(10, 40);
    end
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= f;
    position_i <= p;
    word_in_i  <= w;
    do @(posedge clk_i); while (busy);
    sb.note_command(f, p, w);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_capacity(value);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command(int grow_pct);
    int n;
    int r;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    n = sb.occ;
    r = $urandom_range(0, 99);
    if (r < grow_pct) begin
      f = $urandom_range(0, 1) ? F_INSERT : F_APPEND;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30) f = F_READ;
      else if (r < 57) f = F_DELETE;
      else if (r < 88) f = F_EDIT;
      else if (r < 90) f = F_CLEAR;
      else if (r < 94) f = $urandom_range(0, 1) ? F_SPARE6 : F_SPARE7;
      else f = F_INSERT;
    end
    if ($urandom_range(0, 99) < 12) p = POS_W'($urandom_range(0, 127));
    else if (f == F_INSERT) p = POS_W'($urandom_range(0, n));
    else if (n > 0) p = POS_W'($urandom_range(0, n - 1));
    else p = POS_W'($urandom_range(0, 127));
    send_command(f, p, random_word());
  endtask

  initial begin
    logic [CAP_W-1:0] caps [12];
    caps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd40, 7'd64, 7'd10, 7'd127,
             7'd0, 7'd64};
    caps[6]  = CAP_W'($urandom_range(3, 63));
    caps[11] = CAP_W'($urandom_range(1, 127));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(F_READ,   7'd0,   32'h1234_5678);
    send_command(F_DELETE, 7'd0,   32'h0);
    send_command(F_EDIT,   7'd0,   32'hdead_beef);
    send_command(F_INSERT, 7'd1,   32'h1);
    send_command(F_APPEND, 7'd0,   32'h7fff_ffff);
    send_command(F_APPEND, 7'd127, 32'h8000_0000);
    send_command(F_INSERT, 7'd0,   32'h0);
    send_command(F_INSERT, 7'd3,   32'hffff_ffff);
    send_command(F_INSERT, 7'd127, 32'h5);
    send_command(F_READ,   7'd0,   32'h0);
    send_command(F_READ,   7'd3,   32'h0);
    send_command(F_READ,   7'd4,   32'h0);
    send_command(F_EDIT,   7'd1,   32'h5555_aaaa);
    send_command(F_READ,   7'd1,   32'h0);
    send_command(F_DELETE, 7'd0,   32'h0);
    send_command(F_DELETE, 7'd2,   32'h0);
    send_command(F_DELETE, 7'd64,  32'h0);
    send_command(F_SPARE6, 7'd0,   32'hffff_ffff);
    send_command(F_SPARE7, 7'd1,   32'h0);
    send_command(F_READ,   7'd1,   32'h0);
    send_command(F_CLEAR,  7'd0,   32'h0);
    send_command(F_READ,   7'd0,   32'h0);
    write_capacity(7'd1);
    send_command(F_APPEND, 7'd0,   32'haaaa_5555);
    send_command(F_APPEND, 7'd0,   32'h1);
    send_command(F_INSERT, 7'd0,   32'h2);
    send_command(F_INSERT, 7'd2,   32'h3);

    foreach (caps[ph]) begin
      write_capacity(caps[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_command((ph % 2 == 0) ? 72 : 35);
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
